// ===== hw/rtl/sre_pkg.sv =====
// Shared types and constants of the Sobel row edge detector.
`default_nettype none

package sre_pkg;

  localparam int PIX_W       = 8;
  localparam int COL_W       = 12;
  localparam int ROW_W       = 12;
  localparam int VAL_W       = 11;
  localparam int GRAD_W      = 11;
  localparam int SQ_W        = 20;
  localparam int SUM_W       = 21;
  localparam int ROOT_W      = 22;
  localparam int ROOT_STEPS  = 11;
  localparam int STEP_W      = 4;
  localparam int WIDTH_W     = 13;
  localparam int MARGIN_W    = 7;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 13;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [VAL_W-1:0] CLEAN_HIGH = VAL_W'(255);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_WIDTH  = 3'd0,
    REG_MARGIN     = 3'd1,
    REG_ROW_INDEX  = 3'd2,
    REG_H_ENABLE   = 3'd3,
    REG_V_ENABLE   = 3'd4,
    REG_CLEAN      = 3'd5,
    REG_THRESHOLD  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [WIDTH_W-1:0]  row_width;
    logic [MARGIN_W-1:0] margin;
    logic [ROW_W-1:0]    row_index;
    logic                h_enable;
    logic                v_enable;
    logic                clean_enable;
    logic [VAL_W-1:0]    threshold;
  } cfg_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic [COL_W-1:0]         column;
    logic                     last;
    logic                     row_start;
  } job_t;

  typedef struct packed {
    logic [PIX_W-1:0] above;
    logic [PIX_W-1:0] center;
    logic [PIX_W-1:0] below;
  } pix_col_t;

  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic [VAL_W-1:0] edge_value;
    logic             is_edge;
    logic             last;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sre_front.sv =====
// Front end: column window, column counter, span test and gradient sums.
`default_nettype none

module sre_front #(
  parameter int MAX_WIDTH = 4096
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire sre_pkg::cfg_t  cfg,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire sre_pkg::pix_col_t in_col,
  input  wire                 queue_full,
  output logic                push,
  output sre_pkg::job_t       push_job
);
  import sre_pkg::*;

  localparam int CNT_W = $clog2(MAX_WIDTH);
  localparam int MW_W  = $clog2(MAX_WIDTH + 1);
  localparam int EW    = ((MW_W > WIDTH_W) ? MW_W : WIDTH_W) + 1;
  localparam logic [EW-1:0] MAX_W_E = EW'(MAX_WIDTH);
  localparam logic [EW-1:0] MIN_W_E = EW'(3);

  pix_col_t          win0;
  pix_col_t          win1;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic              row_start;

  logic              accept;
  logic              produce;
  logic [EW-1:0]     width_e;
  logic [EW-1:0]     count_e;
  logic [EW-1:0]     col_e;
  logic [EW-1:0]     m_e;
  logic [EW-1:0]     last_e;
  logic [PIX_W+1:0]  sum_a;
  logic [PIX_W+1:0]  sum_b;
  logic [PIX_W+1:0]  sum_l;
  logic [PIX_W+1:0]  sum_r;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    width_e = EW'(cfg.row_width);
    if (width_e < MIN_W_E) width_e = MIN_W_E;
    if (width_e > MAX_W_E) width_e = MAX_W_E;
    m_e     = (cfg.margin == '0) ? EW'(1) : EW'(cfg.margin);
    count_e = EW'(count);
    col_e   = count_e - EW'(1);
    last_e  = width_e - m_e - EW'(1);
    produce = (count_e < width_e) && (count != '0) && ((m_e << 1) < width_e) &&
              (col_e >= m_e) && (col_e <= last_e);
    count_next = ((count_e + EW'(1)) >= width_e) ? '0 : count + CNT_W'(1);
  end

  // Column sums: win1 is the left neighbour, win0 the centre, in_col the right.
  always_comb begin
    sum_a = {2'b00, win1.above} + {1'b0, win0.above, 1'b0} + {2'b00, in_col.above};
    sum_b = {2'b00, win1.below} + {1'b0, win0.below, 1'b0} + {2'b00, in_col.below};
    sum_l = {2'b00, win1.above} + {1'b0, win1.center, 1'b0} + {2'b00, win1.below};
    sum_r = {2'b00, in_col.above} + {1'b0, in_col.center, 1'b0} + {2'b00, in_col.below};
  end

  assign push = accept && produce;

  always_comb begin
    push_job.gx        = cfg.h_enable ?
                         ($signed({1'b0, sum_a}) - $signed({1'b0, sum_b})) : '0;
    push_job.gy        = cfg.v_enable ?
                         ($signed({1'b0, sum_l}) - $signed({1'b0, sum_r})) : '0;
    push_job.column    = col_e[COL_W-1:0];
    push_job.last      = (col_e == last_e);
    push_job.row_start = row_start;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win0      <= '0;
      win1      <= '0;
      count     <= '0;
      row_start <= 1'b0;
    end else if (accept) begin
      win1  <= win0;
      win0  <= in_col;
      count <= count_next;
      // Column 0 restarts suppression; the flag rides with the next request.
      if (count == '0) begin
        row_start <= 1'b1;
      end else if (produce) begin
        row_start <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sre_queue.sv =====
// Short request queue between front and back end.
`default_nettype none

module sre_queue (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push,
  input  wire sre_pkg::job_t  push_job,
  input  wire                 pop,
  output sre_pkg::job_t       head,
  output logic                full,
  output logic                empty
);
  import sre_pkg::*;

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sre_back.sv =====
// Back end: squares, iterative square root, cleanup and output register.
`default_nettype none

module sre_back (
  input  wire                 clk,
  input  wire                 rst,
  input  wire sre_pkg::cfg_t  cfg,
  input  wire sre_pkg::job_t  head,
  input  wire                 empty,
  output logic                pop,
  output logic                out_valid,
  input  wire                 out_ready,
  output sre_pkg::result_t    out_data
);
  import sre_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_ROOT,
    ST_DONE
  } state_t;

  state_t              state;
  job_t                job;
  logic [SQ_W-1:0]     sq_x;
  logic [SQ_W-1:0]     sq_y;
  logic [SUM_W-1:0]    rem;
  logic [ROOT_W-1:0]   res;
  logic [STEP_W-1:0]   step;
  logic [MARGIN_W-1:0] sup;

  logic [2*GRAD_W-1:0] prod_x;
  logic [2*GRAD_W-1:0] prod_y;
  logic [ROOT_W-1:0]   root_bit;
  logic [ROOT_W-1:0]   trial;
  logic                take;
  logic [VAL_W-1:0]    mag;
  logic [VAL_W-1:0]    val;
  logic [MARGIN_W-1:0] sup_start;
  logic [MARGIN_W-1:0] sup_next;
  logic                out_free;

  assign pop      = (state == ST_IDLE) && !empty;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    prod_x   = $signed(job.gx) * $signed(job.gx);
    prod_y   = $signed(job.gy) * $signed(job.gy);
    root_bit = ROOT_W'(1) << {step, 1'b0};
    trial    = res + root_bit;
    take     = ({1'b0, rem} >= trial);
  end

  // With cleanup enabled, binarise and suppress the following columns after an edge.
  always_comb begin
    mag       = res[VAL_W-1:0];
    sup_start = job.row_start ? '0 : sup;
    val       = mag;
    sup_next  = sup_start;
    if (cfg.clean_enable) begin
      if (sup_start != '0) begin
        val      = '0;
        sup_next = sup_start - MARGIN_W'(1);
      end else if (mag >= cfg.threshold) begin
        val      = CLEAN_HIGH;
        sup_next = ((cfg.margin == '0) ? MARGIN_W'(1) : cfg.margin) - MARGIN_W'(1);
      end else begin
        val      = '0;
      end
    end
    if (job.last) sup_next = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      sup       <= '0;
      step      <= '0;
    end else begin
      if ((state == ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!empty) begin
            job   <= head;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          sq_x  <= prod_x[SQ_W-1:0];
          sq_y  <= prod_y[SQ_W-1:0];
          state <= ST_ADD;
        end
        ST_ADD: begin
          rem   <= SUM_W'(sq_x) + SUM_W'(sq_y);
          res   <= '0;
          step  <= STEP_W'(ROOT_STEPS - 1);
          state <= ST_ROOT;
        end
        ST_ROOT: begin
          if (take) begin
            rem <= rem - trial[SUM_W-1:0];
            res <= (res >> 1) + root_bit;
          end else begin
            res <= res >> 1;
          end
          if (step == '0) begin
            state <= ST_DONE;
          end else begin
            step <= step - STEP_W'(1);
          end
        end
        ST_DONE: begin
          // Hold the result until the output register is free.
          if (out_free) begin
            out_data.column     <= job.column;
            out_data.row        <= cfg.row_index;
            out_data.edge_value <= val;
            out_data.is_edge    <= (val >= cfg.threshold);
            out_data.last       <= job.last;
            sup                 <= sup_next;
            state               <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sobel_row_edge_detector_unit.sv =====
// Top level of the Sobel row edge detector: registers, front, queue, back.
//
//   channel  direction  handshake              payload
//   s_*      in         s_tvalid / s_tready    s_tdata: pixel_above, pixel_center, pixel_below
//   m_*      out        m_tvalid / m_tready    m_tdata: column, row, edge_value, is_edge;
//                                              m_tlast: last
//   cfg_*    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A column that yields no result is taken whenever the queue is not full. A result column
// goes through the back end in order: dequeue, square, sum, 11 root steps and output write;
// the square root settles one bit a step. A four-entry queue lets the front keep taking
// columns meanwhile. Reset is synchronous and clears all control state.
// A stalled m_tready holds the result in the output register and lets the queue fill.
`default_nettype none

module sobel_row_edge_detector_unit #(
  parameter int MAX_WIDTH = 4096
) (
  input  wire                                clk,
  input  wire                                rst,
  // pixel_above [7:0], pixel_center [15:8], pixel_below [23:16]
  input  wire [sre_pkg::IN_TDATA_W-1:0]      s_tdata,
  input  wire                                s_tvalid,
  output logic                               s_tready,
  // column [11:0], row [23:12], edge_value [34:24], is_edge [35], zero [39:36]
  output logic [sre_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic                               m_tlast,
  output logic                               m_tvalid,
  input  wire                                m_tready,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire [sre_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [sre_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import sre_pkg::*;

  cfg_t     cfg;
  pix_col_t in_col;
  job_t     push_job;
  job_t     head;
  result_t  out_data;
  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_width    <= WIDTH_W'(640);
      cfg.margin       <= MARGIN_W'(3);
      cfg.row_index    <= '0;
      cfg.h_enable     <= 1'b0;
      cfg.v_enable     <= 1'b1;
      cfg.clean_enable <= 1'b1;
      cfg.threshold    <= VAL_W'(100);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROW_WIDTH: cfg.row_width    <= cfg_data[WIDTH_W-1:0];
        REG_MARGIN:    cfg.margin       <= cfg_data[MARGIN_W-1:0];
        REG_ROW_INDEX: cfg.row_index    <= cfg_data[ROW_W-1:0];
        REG_H_ENABLE:  cfg.h_enable     <= cfg_data[0];
        REG_V_ENABLE:  cfg.v_enable     <= cfg_data[0];
        REG_CLEAN:     cfg.clean_enable <= cfg_data[0];
        REG_THRESHOLD: cfg.threshold    <= cfg_data[VAL_W-1:0];
        default:       cfg              <= cfg;
      endcase
    end
  end

  assign in_col.above  = s_tdata[PIX_W-1:0];
  assign in_col.center = s_tdata[2*PIX_W-1:PIX_W];
  assign in_col.below  = s_tdata[3*PIX_W-1:2*PIX_W];

  sre_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_col     (in_col),
    .queue_full (q_full),
    .push       (push),
    .push_job   (push_job)
  );

  sre_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  sre_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data)
  );

  assign m_tdata = {4'b0000, out_data.is_edge, out_data.edge_value,
                    out_data.row, out_data.column};
  assign m_tlast = out_data.last;

endmodule

`default_nettype wire

// ===== hw/rtl/sre_checker.sv =====
// Port-level checks of the edge detector, bound to the top level.
`default_nettype none

module sre_checker (
  input wire                               clk,
  input wire                               rst,
  input wire                               m_tvalid,
  input wire                               m_tready,
  input wire [sre_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input wire                               m_tlast
);
  import sre_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid)
    else $error("result shown right after reset");

  a_value_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[34:24] <= VAL_W'(1442)) && (m_tdata[39:36] == 4'b0000))
    else $error("edge value out of range or padding set");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("stalled result dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

endmodule

bind sobel_row_edge_detector_unit sre_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== tb/sre_edge_checker.sv =====
// Checker for the Sobel row edge detector: tracks registers, predicts results, compares them.
module sre_edge_checker #(
  parameter int MAX_WIDTH = 4096
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire [sre_pkg::IN_TDATA_W-1:0]      s_tdata,
  input  wire                                s_tvalid,
  input  wire                                s_tready,
  input  wire [sre_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input  wire                                m_tlast,
  input  wire                                m_tvalid,
  input  wire                                m_tready,
  input  wire                                cfg_valid,
  input  wire                                cfg_ready,
  input  wire [sre_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [sre_pkg::CFG_DATA_W-1:0]      cfg_data,
  output int                                 mismatches,
  output int                                 outstanding
);
  import sre_pkg::*;

  cfg_t     regs;
  pix_col_t win_near;   // previous column
  pix_col_t win_far;    // column before that
  int       col_pos;
  int       quiet_left;
  result_t  expected_edges[$];

  function automatic int floor_root(input int v);
    int r;
    int t;
    int b;
    r = 0;
    for (b = 10; b >= 0; b--) begin
      t = r | (1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  task automatic predict_column(input pix_col_t cur);
    int      width, m, n, w, wlast, gx, gy, mag, val;
    int      af, cf, bf, an, bn, ac, cc, bc;
    result_t r;
    width = regs.row_width;
    if (width < 3) width = 3;
    if (width > MAX_WIDTH) width = MAX_WIDTH;
    m = (regs.margin == 0) ? 1 : regs.margin;
    n = col_pos;
    af = win_far.above;  cf = win_far.center;  bf = win_far.below;
    an = win_near.above; bn = win_near.below;
    ac = cur.above;      cc = cur.center;      bc = cur.below;
    // a fresh row never inherits a suppression run
    if (n == 0) quiet_left = 0;
    if (n < width && n >= 1 && 2 * m < width) begin
      w = n - 1;
      wlast = width - m - 1;
      if (w >= m && w <= wlast) begin
        gx = regs.h_enable ? (af + 2 * an + ac) - (bf + 2 * bn + bc) : 0;
        gy = regs.v_enable ? (af + 2 * cf + bf) - (ac + 2 * cc + bc) : 0;
        mag = floor_root(gx * gx + gy * gy);
        val = mag;
        if (regs.clean_enable) begin
          if (quiet_left != 0) begin
            val = 0;
            quiet_left--;
          end else if (mag >= int'(regs.threshold)) begin
            val = 255;
            quiet_left = m - 1;
          end else begin
            val = 0;
          end
        end
        if (w == wlast) quiet_left = 0;
        r.column     = COL_W'(w);
        r.row        = regs.row_index;
        r.edge_value = VAL_W'(val);
        r.is_edge    = (val >= int'(regs.threshold));
        r.last       = (w == wlast);
        expected_edges = {expected_edges, r};
      end
    end
    win_far  = win_near;
    win_near = cur;
    col_pos  = (n + 1 >= width) ? 0 : n + 1;
  endtask

  always @(posedge clk) begin
    result_t  got;
    result_t  want;
    pix_col_t cur;
    if (rst) begin
      regs.row_width    = WIDTH_W'(640);
      regs.margin       = MARGIN_W'(3);
      regs.row_index    = '0;
      regs.h_enable     = 1'b0;
      regs.v_enable     = 1'b1;
      regs.clean_enable = 1'b1;
      regs.threshold    = VAL_W'(100);
      win_near          = '0;
      win_far           = '0;
      col_pos           = 0;
      quiet_left        = 0;
      mismatches        = 0;
      expected_edges.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.column     = m_tdata[11:0];
        got.row        = m_tdata[23:12];
        got.edge_value = m_tdata[34:24];
        got.is_edge    = m_tdata[35];
        got.last       = m_tlast;
        if (expected_edges.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: col %0d row %0d value %0d edge %0d last %0d",
                   $time, got.column, got.row, got.edge_value, got.is_edge, got.last);
        end else begin
          want = expected_edges.pop_front();
          if (got !== want) begin
            mismatches++;
            $display("%0t: expected col %0d row %0d value %0d edge %0d last %0d",
                     $time, want.column, want.row, want.edge_value, want.is_edge, want.last);
            $display("%0t: actual   col %0d row %0d value %0d edge %0d last %0d",
                     $time, got.column, got.row, got.edge_value, got.is_edge, got.last);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_ROW_WIDTH: regs.row_width    = cfg_data[WIDTH_W-1:0];
          REG_MARGIN:    regs.margin       = cfg_data[MARGIN_W-1:0];
          REG_ROW_INDEX: regs.row_index    = cfg_data[ROW_W-1:0];
          REG_H_ENABLE:  regs.h_enable     = cfg_data[0];
          REG_V_ENABLE:  regs.v_enable     = cfg_data[0];
          REG_CLEAN:     regs.clean_enable = cfg_data[0];
          REG_THRESHOLD: regs.threshold    = cfg_data[VAL_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        cur.above  = s_tdata[7:0];
        cur.center = s_tdata[15:8];
        cur.below  = s_tdata[23:16];
        predict_column(cur);
      end
    end
    outstanding = expected_edges.size();
  end

endmodule

// ===== tb/tb_sobel_row_edge_detector_unit.sv =====
// Testbench top for the Sobel row edge detector: stimulus, flow control and verdict.
module tb_sobel_row_edge_detector_unit;
  import sre_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 32;

  typedef enum int {CORNERS, NOISE, SCENE} column_style_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int mismatches;
  int outstanding;
  int sender_idle = 0;
  int receiver_idle = 0;
  bit burst = 1'b0;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  sobel_row_edge_detector_unit #(.MAX_WIDTH(4096)) dut (
    .clk, .rst, .s_tdata, .s_tvalid, .s_tready, .m_tdata, .m_tlast, .m_tvalid, .m_tready,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  sre_edge_checker #(.MAX_WIDTH(4096)) scoreboard (
    .clk, .rst, .s_tdata, .s_tvalid, .s_tready, .m_tdata, .m_tlast, .m_tvalid, .m_tready,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .mismatches, .outstanding
  );

  // Result side: random back-pressure, or one long hold when asked.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= burst || ($urandom_range(99) >= receiver_idle);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_column(input pix_col_t c);
    while (!burst && $urandom_range(99) < sender_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {c.below, c.center, c.above};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic stream_columns(input int count, input column_style_t style);
    pix_col_t c;
    int       k;
    int       ba, bc, bb;
    logic [23:0] corners [8];
    corners = '{24'h000000, 24'hFFFFFF, 24'h0000FF, 24'hFF0000,
                24'h00FF00, 24'hFFFFFF, 24'h000000, 24'hFF00FF};
    ba = $urandom_range(255);
    bc = $urandom_range(255);
    bb = $urandom_range(255);
    for (k = 0; k < count; k++) begin
      case (style)
        CORNERS: c = pix_col_t'(corners[k % 8]);
        NOISE:   c = pix_col_t'($urandom());
        default: begin
          // mostly flat rows with jitter and the odd step edge
          if ($urandom_range(7) == 0) ba = $urandom_range(255);
          if ($urandom_range(7) == 0) bc = $urandom_range(255);
          if ($urandom_range(7) == 0) bb = $urandom_range(255);
          c.above  = 8'(ba) ^ 8'($urandom_range(7));
          c.center = 8'(bc) ^ 8'($urandom_range(7));
          c.below  = 8'(bb) ^ 8'($urandom_range(7));
        end
      endcase
      send_column(c);
    end
  endtask

  // Drop the stream and let the block drain before touching registers.
  task automatic settle_unit();
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic program_unit(input logic [WIDTH_W-1:0] width, input logic [MARGIN_W-1:0] margin,
                              input logic [ROW_W-1:0] row, input logic h_on, input logic v_on,
                              input logic clean_on, input logic [VAL_W-1:0] thr);
    settle_unit();
    write_register(REG_ROW_WIDTH, CFG_DATA_W'(width));
    write_register(REG_MARGIN, CFG_DATA_W'(margin));
    write_register(REG_ROW_INDEX, CFG_DATA_W'(row));
    write_register(REG_H_ENABLE, CFG_DATA_W'(h_on));
    write_register(REG_V_ENABLE, CFG_DATA_W'(v_on));
    write_register(REG_CLEAN, CFG_DATA_W'(clean_on));
    write_register(REG_THRESHOLD, CFG_DATA_W'(thr));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int                  random_items;
    int                  count;
    int                  pick;
    bit                  squeezed;
    bit                  widest;
    logic [WIDTH_W-1:0]  width;
    logic [MARGIN_W-1:0] margin;
    logic [VAL_W-1:0]    thr;
    random_items = 0;
    squeezed = 1'b0;
    widest = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    sender_idle = 15;
    receiver_idle = 88;
    // reset settings first, then short directed rows
    stream_columns(5, CORNERS);
    program_unit(8, 1, 12'hFFF, 1'b1, 1'b1, 1'b0, 0);
    stream_columns(8, CORNERS);
    // width below three clamps, margin zero acts as one, lowered width ends the row
    program_unit(0, 0, 0, 1'b1, 1'b0, 1'b1, 0);
    stream_columns(4, CORNERS);
    // span too narrow for any result
    program_unit(6, 3, 12'h555, 1'b1, 1'b1, 1'b0, 0);
    stream_columns(3, NOISE);
    // suppression run that reaches the span end
    program_unit(9, 3, 12'hAAA, 1'b1, 1'b1, 1'b1, 1);
    stream_columns(9, NOISE);

    while (random_items < 800) begin
      if (random_items < 270) begin
        sender_idle = 15;
        receiver_idle = 88;
      end else if (random_items < 540) begin
        sender_idle = 88;
        receiver_idle = 15;
      end else begin
        sender_idle = 0;
        receiver_idle = 0;
      end
      burst = ($urandom_range(3) == 0);
      if (random_items >= 540 && !squeezed) begin
        // hold results off while columns keep coming, so the input backs up
        squeezed = 1'b1;
        burst = 1'b1;
        program_unit(40, 1, ROW_W'($urandom()), 1'b1, 1'b1, 1'b0, 0);
        hold_request = 1'b1;
        stream_columns(60, SCENE);
        random_items += 60;
      end else if (random_items >= 640 && !widest) begin
        widest = 1'b1;
        burst = 1'b1;
        program_unit(300, 127, 12'hFFF, 1'b1, 1'b1, 1'b1, VAL_W'($urandom_range(600)));
        stream_columns(300, SCENE);
        random_items += 300;
      end else begin
        pick = $urandom_range(9);
        if (pick == 0) width = WIDTH_W'($urandom_range(2));
        else if (pick == 1) width = 8191;
        else width = WIDTH_W'($urandom_range(3, 48));
        if ($urandom_range(5) == 0) margin = MARGIN_W'($urandom_range(127));
        else margin = MARGIN_W'($urandom_range(6));
        pick = $urandom_range(5);
        if (pick == 0) thr = 0;
        else if (pick == 1) thr = 1443;
        else if (pick == 2) thr = VAL_W'($urandom());
        else thr = VAL_W'($urandom_range(500));
        program_unit(width, margin, ROW_W'($urandom()), 1'($urandom()), 1'($urandom()),
                     1'($urandom()), thr);
        count = $urandom_range(4, 60);
        stream_columns(count, ($urandom_range(2) == 0) ? NOISE : SCENE);
        random_items += count;
      end
    end

    settle_unit();
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/sre_pkg.sv
hw/rtl/sre_front.sv
hw/rtl/sre_queue.sv
hw/rtl/sre_back.sv
hw/rtl/sobel_row_edge_detector_unit.sv
hw/rtl/sre_checker.sv
tb/sre_edge_checker.sv
tb/tb_sobel_row_edge_detector_unit.sv
